// ===== rtl/ilb_pkg.sv =====
package ilb_pkg;

    localparam int AccWidth  = 64;
    localparam int ProdWidth = AccWidth + 4;

    localparam logic [7:0] CH_UNDERSCORE   = 8'h5F;
    localparam logic [7:0] CH_ZERO         = 8'h30;
    localparam logic [7:0] CH_NINE         = 8'h39;
    localparam logic [7:0] CH_LOWER_B      = 8'h62;
    localparam logic [7:0] CH_LOWER_X      = 8'h78;
    localparam logic [7:0] HEX_LETTER_BIAS = 8'h37;   // 'A' - 10

    localparam logic [3:0] TYPE_I8  = 4'd0;
    localparam logic [3:0] TYPE_I16 = 4'd1;
    localparam logic [3:0] TYPE_I32 = 4'd2;
    localparam logic [3:0] TYPE_I64 = 4'd3;
    localparam logic [3:0] TYPE_U8  = 4'd4;
    localparam logic [3:0] TYPE_U16 = 4'd5;
    localparam logic [3:0] TYPE_U32 = 4'd6;
    localparam logic [3:0] TYPE_U64 = 4'd7;

    typedef enum logic [1:0] {
        POS_FIRST,
        POS_SECOND,
        POS_LATER
    } pos_t;

    typedef enum logic [1:0] {
        BASE_DEC,
        BASE_BIN,
        BASE_HEX
    } base_t;

    typedef struct packed {
        logic [7:0] character;
        logic [3:0] target_type;
        logic       last_char;
    } item_t;

    typedef struct packed {
        logic [AccWidth-1:0] value;
        logic                overflow;
        logic                type_error;
    } result_t;

    function automatic logic type_is_int(input logic [3:0] t);
        return (t <= TYPE_U64);
    endfunction

    function automatic logic [AccWidth-1:0] type_max(input logic [3:0] t);
        logic [AccWidth-1:0] m;
        case (t)
            TYPE_I8:  m = 64'h0000_0000_0000_007F;
            TYPE_I16: m = 64'h0000_0000_0000_7FFF;
            TYPE_I32: m = 64'h0000_0000_7FFF_FFFF;
            TYPE_I64: m = 64'h7FFF_FFFF_FFFF_FFFF;
            TYPE_U8:  m = 64'h0000_0000_0000_00FF;
            TYPE_U16: m = 64'h0000_0000_0000_FFFF;
            TYPE_U32: m = 64'h0000_0000_FFFF_FFFF;
            default:  m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [AccWidth-1:0] type_mask(input logic [3:0] t);
        logic [AccWidth-1:0] m;
        case (t[1:0])
            2'd0:    m = 64'h0000_0000_0000_00FF;
            2'd1:    m = 64'h0000_0000_0000_FFFF;
            2'd2:    m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/ilb_if.sv =====
interface ilb_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic [3:0] target_type;
    logic       last_char;

    modport source (output valid, output character, output target_type, output last_char,
                    input ready);
    modport sink   (input valid, input character, input target_type, input last_char,
                    output ready);
endinterface

interface ilb_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic        overflow;
    logic        type_error;

    modport source (output valid, output value, output overflow, output type_error,
                    input ready);
    modport sink   (input valid, input value, input overflow, input type_error,
                    output ready);
endinterface

// ===== rtl/ilb_in_reg.sv =====
module ilb_in_reg (
    input  logic           clk,
    input  logic           rst_n,
    ilb_char_if.sink       chars,
    input  logic           consume,
    output logic           item_valid,
    output ilb_pkg::item_t item
);
    import ilb_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    logic  take;

    assign chars.ready = !valid_reg || consume;
    assign take        = chars.valid && chars.ready;
    assign item_valid  = valid_reg;
    assign item        = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (chars.ready)
        begin
            valid_reg <= chars.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.character   <= chars.character;
            item_reg.target_type <= chars.target_type;
            item_reg.last_char   <= chars.last_char;
        end
    end

endmodule

// ===== rtl/ilb_fold.sv =====
module ilb_fold (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  ilb_pkg::item_t   item,
    input  logic             out_room,
    output logic             consume,
    output logic             res_load,
    output ilb_pkg::result_t result
);
    import ilb_pkg::*;

    pos_t                pos_reg,        pos_next;
    base_t               base_reg,       base_next;
    logic                first_zero_reg, first_zero_next;
    logic [AccWidth-1:0] acc_reg,        acc_next;
    logic                ovf_reg,        ovf_next;
    logic [3:0]          type_reg,       type_next;

    logic [3:0]           eff_type;
    logic                 prefix;
    logic                 do_fold;
    logic [7:0]           digit;
    logic [ProdWidth-1:0] prod;
    logic [ProdWidth-1:0] sum;
    logic                 carry;
    logic                 step_ovf;
    logic [AccWidth-1:0]  acc_new;
    logic                 ovf_new;

    // a last character needs a free result slot; others go straight through
    assign consume  = item_valid && (!item.last_char || out_room);
    assign res_load = consume && item.last_char;

    assign eff_type = (pos_reg == POS_FIRST) ? item.target_type : type_reg;
    assign prefix   = (pos_reg == POS_SECOND) && first_zero_reg &&
                      (item.character == CH_LOWER_B || item.character == CH_LOWER_X);
    assign do_fold  = !prefix && (item.character != CH_UNDERSCORE);
    assign digit    = (item.character <= CH_NINE) ? (item.character - CH_ZERO)
                                                  : (item.character - HEX_LETTER_BIAS);

    always_comb
    begin
        case (base_reg)
            BASE_BIN: prod = {3'b000, acc_reg, 1'b0};
            BASE_HEX: prod = {acc_reg, 4'b0000};
            default:  prod = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0};
        endcase
    end

    assign sum      = prod + {{(ProdWidth-8){1'b0}}, digit};
    assign carry    = |sum[ProdWidth-1:AccWidth];
    assign step_ovf = type_is_int(eff_type) &&
                      (carry || (sum[AccWidth-1:0] > type_max(eff_type)));
    assign acc_new  = do_fold ? sum[AccWidth-1:0] : acc_reg;
    assign ovf_new  = ovf_reg || (do_fold && step_ovf);

    always_comb
    begin
        result.value      = type_is_int(eff_type) ? (acc_new & type_mask(eff_type)) : acc_new;
        result.overflow   = type_is_int(eff_type) && ovf_new;
        result.type_error = !type_is_int(eff_type);
    end

    always_comb
    begin
        pos_next        = pos_reg;
        base_next       = base_reg;
        first_zero_next = first_zero_reg;
        acc_next        = acc_reg;
        ovf_next        = ovf_reg;
        type_next       = type_reg;
        if (consume)
        begin
            if (item.last_char)
            begin
                pos_next        = POS_FIRST;
                base_next       = BASE_DEC;
                first_zero_next = 1'b0;
                acc_next        = '0;
                ovf_next        = 1'b0;
                type_next       = TYPE_I8;
            end
            else
            begin
                acc_next = acc_new;
                ovf_next = ovf_new;
                case (pos_reg)
                    POS_FIRST:
                    begin
                        pos_next        = POS_SECOND;
                        type_next       = item.target_type;
                        first_zero_next = (item.character == CH_ZERO);
                    end
                    POS_SECOND:
                    begin
                        pos_next = POS_LATER;
                        if (prefix)
                        begin
                            base_next = (item.character == CH_LOWER_B) ? BASE_BIN : BASE_HEX;
                        end
                    end
                    default:
                    begin
                        pos_next = POS_LATER;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= POS_FIRST;
            base_reg       <= BASE_DEC;
            first_zero_reg <= 1'b0;
            acc_reg        <= '0;
            ovf_reg        <= 1'b0;
            type_reg       <= TYPE_I8;
        end
        else
        begin
            pos_reg        <= pos_next;
            base_reg       <= base_next;
            first_zero_reg <= first_zero_next;
            acc_reg        <= acc_next;
            ovf_reg        <= ovf_next;
            type_reg       <= type_next;
        end
    end

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> (pos_reg == POS_FIRST) && (acc_reg == '0) && !ovf_reg &&
                     (base_reg == BASE_DEC))
        else $error("state not cleared after last character");

    a_load_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> out_room)
        else $error("result loaded into a full output register");

    a_fresh_literal: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg == POS_FIRST) |-> (acc_reg == '0) && !ovf_reg && !first_zero_reg)
        else $error("stale state at start of literal");

    a_base_only_decimal_early: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg != POS_LATER) |-> (base_reg == BASE_DEC))
        else $error("base changed before the prefix position");

endmodule

// ===== rtl/ilb_out_reg.sv =====
module ilb_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_load,
    input  ilb_pkg::result_t result,
    output logic             out_room,
    ilb_result_if.source     results
);
    import ilb_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign out_room           = !valid_reg || results.ready;
    assign results.valid      = valid_reg;
    assign results.value      = data_reg.value;
    assign results.overflow   = data_reg.overflow;
    assign results.type_error = data_reg.type_error;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_room)
        begin
            valid_reg <= res_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            data_reg <= result;
        end
    end

endmodule

// ===== rtl/integer_literal_to_binary_unit.sv =====
// Converts an integer literal, streamed one ASCII character per transaction, to a 64-bit
// value: "0b"/"0x" prefixes select base 2/16, otherwise base 10; underscores are skipped.
// One character is taken every cycle; only a last character waits for room in the
// result register. The last character passes the input register, then its result is
// loaded into the result register as the next literal's first character can be taken.
// The rate is set by the accumulator loop: a constant-base shift-add and a 68-bit add
// with the overflow compare against the type limit. target_type is read on the first
// character only; type codes above 7 give type_error with the raw 64-bit accumulator.
module integer_literal_to_binary_unit (
    input  logic         clk,
    input  logic         rst_n,
    ilb_char_if.sink     chars,
    ilb_result_if.source result
);
    import ilb_pkg::*;

    logic    item_valid;
    item_t   item;
    logic    consume;
    logic    res_load;
    logic    out_room;
    result_t res_data;

    ilb_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .consume    (consume),
        .item_valid (item_valid),
        .item       (item)
    );

    ilb_fold u_fold (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_room   (out_room),
        .consume    (consume),
        .res_load   (res_load),
        .result     (res_data)
    );

    ilb_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_load (res_load),
        .result   (res_data),
        .out_room (out_room),
        .results  (result)
    );

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ilb_pkg::*;

    // Tracks the literal being converted and queues the result it must produce.
    class literal_scoreboard;
        pos_t        position;
        logic [4:0]  radix;
        bit          lead_zero;
        logic [63:0] acc;
        bit          ovf;
        logic [3:0]  lit_type;
        result_t     expected_q[$];
        int unsigned mismatches;
        int unsigned literals;
        int unsigned overflows;
        int unsigned type_errors;
        int unsigned checked;

        function new();
            clear();
            mismatches  = 0;
            literals    = 0;
            overflows   = 0;
            type_errors = 0;
            checked     = 0;
        endfunction

        function void clear();
            position  = POS_FIRST;
            radix     = 5'd10;
            lead_zero = 1'b0;
            acc       = '0;
            ovf       = 1'b0;
            lit_type  = TYPE_I8;
        endfunction

        function logic [63:0] width_mask(logic [1:0] sz);
            return {64{1'b1}} >> (64 - (8 << sz));
        endfunction

        function logic [63:0] limit_of(logic [3:0] t);
            if (t < TYPE_U8)
                return width_mask(t[1:0]) >> 1;
            return width_mask(t[1:0]);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void fold(logic [7:0] c);
            logic [7:0]  digit;
            logic [67:0] exact;
            digit = (c <= CH_NINE) ? c - CH_ZERO : c - HEX_LETTER_BIAS;
            exact = {4'd0, acc} * radix + digit;
            // carry past bit 63 is overflow for every integer type
            if (lit_type <= TYPE_U64 && (exact[67:64] != 4'd0 || exact[63:0] > limit_of(lit_type)))
                ovf = 1'b1;
            acc = exact[63:0];
        endfunction

        function void note_char(logic [7:0] c, logic [3:0] t, logic last);
            bit      is_prefix;
            result_t r;
            is_prefix = 1'b0;
            case (position)
                POS_FIRST:
                begin
                    lit_type  = t;
                    lead_zero = (c == CH_ZERO);
                    position  = POS_SECOND;
                end
                POS_SECOND:
                begin
                    if (lead_zero && c == CH_LOWER_B)
                    begin
                        radix     = 5'd2;
                        is_prefix = 1'b1;
                    end
                    else if (lead_zero && c == CH_LOWER_X)
                    begin
                        radix     = 5'd16;
                        is_prefix = 1'b1;
                    end
                    position = POS_LATER;
                end
                default: ;
            endcase
            if (!is_prefix && c != CH_UNDERSCORE)
                fold(c);
            if (last)
            begin
                if (lit_type <= TYPE_U64)
                begin
                    r.value      = acc & width_mask(lit_type[1:0]);
                    r.overflow   = ovf;
                    r.type_error = 1'b0;
                end
                else
                begin
                    r.value      = acc;
                    r.overflow   = 1'b0;
                    r.type_error = 1'b1;
                end
                expected_q.push_back(r);
                literals++;
                if (r.overflow)
                    overflows++;
                if (r.type_error)
                    type_errors++;
                clear();
            end
        endfunction

        function void check_result(logic [63:0] value, logic overflow, logic type_error);
            result_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: value=%h overflow=%b type_error=%b",
                       value, overflow, type_error);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (value !== want.value)
            begin
                $error("value: expected %h, got %h", want.value, value);
                mismatches++;
            end
            if (overflow !== want.overflow)
            begin
                $error("overflow: expected %b, got %b", want.overflow, overflow);
                mismatches++;
            end
            if (type_error !== want.type_error)
            begin
                $error("type_error: expected %b, got %b", want.type_error, type_error);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ilb_char_if   chars();
    ilb_result_if result();

    integer_literal_to_binary_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars),
        .result (result)
    );

    literal_scoreboard sb = new();

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int unsigned sent_chars     = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // both channels are sampled here so each edge sees pre-update values
    always @(posedge clk)
    begin
        if (chars.valid && chars.ready)
            sb.note_char(chars.character, chars.target_type, chars.last_char);
        if (result.valid && result.ready)
            sb.check_result(result.value, result.overflow, result.type_error);
        result.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_char(input logic [7:0] c, input logic [3:0] t, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            chars.valid <= 1'b0;
            @(posedge clk);
        end
        chars.valid       <= 1'b1;
        chars.character   <= c;
        chars.target_type <= t;
        chars.last_char   <= last;
        do
            @(posedge clk);
        while (!chars.ready);
        sent_chars++;
    endtask

    // later characters carry a random type, which the block must ignore
    task automatic send_text(input string s, input logic [3:0] t);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], (i == 0) ? t : 4'($urandom_range(15)), i == s.len() - 1);
    endtask

    task automatic drain();
        chars.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_literal();
        logic [3:0]  ty;
        logic [7:0]  text[$];
        logic [64:0] near;
        string       s;
        int          pick;
        int          kind;
        int          ndig;
        int          maxdig;
        int          d;
        pick = $urandom_range(99);
        if (pick < 80)
            ty = 4'($urandom_range(7));
        else if (pick < 90)
            ty = 4'd8;
        else
            ty = 4'($urandom_range(15, 9));
        pick = $urandom_range(99);
        if (pick < 12)
        begin
            repeat ($urandom_range(8, 1))
                text.push_back(8'($urandom_range(255)));
        end
        else if (pick < 24 && ty <= TYPE_U64)
        begin
            // one below, at, or one above the type maximum
            near = {1'b0, sb.limit_of(ty)} + $urandom_range(2) - 1;
            if ($urandom_range(1) == 1)
                s = $sformatf("%0d", near);
            else
            begin
                s = $sformatf("%0h", near);
                s = {"0x", s.toupper()};
            end
            for (int i = 0; i < s.len(); i++)
                text.push_back(s[i]);
        end
        else
        begin
            kind = $urandom_range(2);
            if (kind == BASE_BIN)
            begin
                text.push_back(CH_ZERO);
                text.push_back(CH_LOWER_B);
            end
            else if (kind == BASE_HEX)
            begin
                text.push_back(CH_ZERO);
                text.push_back(CH_LOWER_X);
            end
            maxdig = (kind == BASE_BIN) ? 66 : (kind == BASE_HEX) ? 18 : 22;
            if ($urandom_range(99) < 15)
                ndig = $urandom_range(maxdig, 1);
            else
                ndig = $urandom_range(6, (kind == BASE_DEC) ? 1 : 0);
            repeat (ndig)
            begin
                if (kind == BASE_BIN)
                    d = $urandom_range(1);
                else if (kind == BASE_HEX)
                    d = $urandom_range(15);
                else
                    d = $urandom_range(9);
                if ($urandom_range(9) == 0)
                    text.push_back(CH_UNDERSCORE);
                if ($urandom_range(19) == 0)
                    text.push_back(8'($urandom_range(255)));
                text.push_back((d < 10) ? 8'(CH_ZERO + d) : 8'(HEX_LETTER_BIAS + d));
            end
            if (text.size() == 0)
                text.push_back(CH_ZERO);
        end
        for (int i = 0; i < text.size(); i++)
            send_char(text[i], (i == 0) ? ty : 4'($urandom_range(15)), i == text.size() - 1);
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        chars.valid       <= 1'b0;
        chars.character   <= '0;
        chars.target_type <= '0;
        chars.last_char   <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 35;
        recv_stall_pct = 72;

        send_text("0", TYPE_I64);
        send_text("0b", TYPE_U16);
        send_text("0x", TYPE_I32);
        send_text("0x_F", TYPE_I16);
        send_text("0b11", TYPE_U8);
        send_text("256", TYPE_U8);
        send_text("128", TYPE_I8);
        send_char(8'h00, TYPE_U32, 1'b0);       // digit wraps modulo 256
        send_char(8'hFF, 4'hF, 1'b1);
        send_text("_9", 4'd8);
        send_text("Z", 4'hF);
        send_text("x", TYPE_U64);

        while (sent_chars < 350)
            send_random_literal();
        drain();
        send_idle_pct  = 72;
        recv_stall_pct = 35;
        while (sent_chars < 700)
            send_random_literal();
        drain();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (sent_chars < 1050)
            send_random_literal();

        chars.valid <= 1'b0;
        @(posedge clk);
        for (int n = 0; n < 5000 && sb.pending() != 0; n++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d literal results never arrived", sb.pending());
            sb.mismatches += sb.pending();
        end

        $display("Sent %0d characters forming %0d literals; %0d results checked.",
                 sent_chars, sb.literals, sb.checked);
        $display("Of those, %0d flagged overflow and %0d a non-integer type.",
                 sb.overflows, sb.type_errors);
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ilb_pkg.sv
rtl/ilb_if.sv
rtl/ilb_in_reg.sv
rtl/ilb_fold.sv
rtl/ilb_out_reg.sv
rtl/integer_literal_to_binary_unit.sv
verif/tb_top.sv
